// ===== hdl/tiny_register_memory_cpu_executor_macros.svh =====
// assertion macros shared by the executor rtl
`ifndef TINY_REGISTER_MEMORY_CPU_EXECUTOR_MACROS_SVH
`define TINY_REGISTER_MEMORY_CPU_EXECUTOR_MACROS_SVH

// condition holds at every clock edge out of reset
`define TRMCE_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// condition holds at the next clock edge out of reset
`define TRMCE_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hdl/trmce_pkg.sv =====
// types, codes and defaults for the register/memory instruction executor
package trmce_pkg;

	localparam int NUM_REGS_DEF  = 5;
	localparam int MEM_WORDS_DEF = 64;
	localparam int DATA_W        = 32;
	localparam int IN_TDATA_W    = 64;
	localparam int OUT_TDATA_W   = 48;

	typedef enum logic [2:0] {
		KIND_MOV = 3'd0,
		KIND_ADD = 3'd1,
		KIND_SUB = 3'd2,
		KIND_PRN = 3'd3,
		KIND_JMP = 3'd4,
		KIND_JPN = 3'd5,
		KIND_HLT = 3'd6
	} kind_t;

	// mov modes
	localparam logic [2:0] MOV_IMM_REG = 3'd0;
	localparam logic [2:0] MOV_REG_REG = 3'd1;
	localparam logic [2:0] MOV_REG_MEM = 3'd2;
	localparam logic [2:0] MOV_IMM_MEM = 3'd3;
	localparam logic [2:0] MOV_MEM_REG = 3'd4;

	// add, sub and prn source modes
	localparam logic [2:0] SRC_IMM = 3'd0;
	localparam logic [2:0] SRC_REG = 3'd1;
	localparam logic [2:0] SRC_MEM = 3'd2;

	// jmp modes
	localparam logic [2:0] JMP_ALWAYS = 3'd0;
	localparam logic [2:0] JMP_ZERO   = 3'd1;

	typedef struct packed {
		logic [7:0]  target;
		logic [30:0] immediate;
		logic [5:0]  address;
		logic [2:0]  reg_b;
		logic [2:0]  reg_a;
		logic [2:0]  mode;
		logic [2:0]  kind;
	} instr_t;

	typedef struct packed {
		logic                     error;
		logic                     halted;
		logic [7:0]               branch_target;
		logic                     branch_taken;
		logic signed [DATA_W-1:0] print_value;
		logic                     print_valid;
	} result_t;

endpackage

// ===== hdl/tiny_register_memory_cpu_executor.sv =====
// an accepted beat is held in the operand-read stage, then executed into the registered result
// one instruction per cycle unless the output stalls; stores read at accept, written at execute
// store writes are forwarded to the next instruction's operand reads, so no stalls
// reset clears pipeline valids, the halt flag and the store valid bits at once
// registers and memory words read as zero until first written
`include "tiny_register_memory_cpu_executor_macros.svh"

module tiny_register_memory_cpu_executor #(
	parameter int NUM_REGS  = trmce_pkg::NUM_REGS_DEF,
	parameter int MEM_WORDS = trmce_pkg::MEM_WORDS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// kind, mode, reg_a, reg_b, address, immediate, target, zero pad
	input  logic [trmce_pkg::IN_TDATA_W-1:0]  s_tdata,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// print_valid, print_value, branch_taken, branch_target, halted, error, zero pad
	output logic [trmce_pkg::OUT_TDATA_W-1:0] m_tdata
);
	import trmce_pkg::*;

	localparam int RIDX_W = $clog2(NUM_REGS);
	localparam int AIDX_W = $clog2(MEM_WORDS);

	instr_t in_instr, instr_s1;
	logic s1_valid_q, out_valid_q, halt_q;
	logic adv, fire, acc;
	result_t res, res_q;
	logic [DATA_W-1:0] ra_val, rb_val, mem_val, reg_wd, mem_wd;
	logic reg_we, mem_we, halt_set, reg_we_g, mem_we_g;
	logic [RIDX_W-1:0] reg_wa;
	logic [AIDX_W-1:0] mem_wa;

	assign in_instr.kind      = s_tdata[2:0];
	assign in_instr.mode      = s_tdata[5:3];
	assign in_instr.reg_a     = s_tdata[8:6];
	assign in_instr.reg_b     = s_tdata[11:9];
	assign in_instr.address   = s_tdata[17:12];
	assign in_instr.immediate = s_tdata[48:18];
	assign in_instr.target    = s_tdata[56:49];

	assign adv      = !out_valid_q || m_tready;
	assign fire     = s1_valid_q && adv;
	assign s_tready = !s1_valid_q || adv;
	assign acc      = s_tvalid && s_tready;
	assign reg_we_g = reg_we && fire;
	assign mem_we_g = mem_we && fire;

	trmce_regfile #(
		.NUM_REGS(NUM_REGS)
	) u_regfile (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd_en    (acc),
		.rd_addr0 (RIDX_W'(in_instr.reg_a)),
		.rd_addr1 (RIDX_W'(in_instr.reg_b)),
		.wr_en    (reg_we_g),
		.wr_addr  (reg_wa),
		.wr_data  (reg_wd),
		.rd_data0 (ra_val),
		.rd_data1 (rb_val)
	);

	trmce_datamem #(
		.MEM_WORDS(MEM_WORDS)
	) u_datamem (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (acc),
		.rd_addr (AIDX_W'(in_instr.address)),
		.wr_en   (mem_we_g),
		.wr_addr (mem_wa),
		.wr_data (mem_wd),
		.rd_data (mem_val)
	);

	trmce_exec #(
		.NUM_REGS  (NUM_REGS),
		.MEM_WORDS (MEM_WORDS)
	) u_exec (
		.instr     (instr_s1),
		.halted_in (halt_q),
		.ra_val    (ra_val),
		.rb_val    (rb_val),
		.mem_val   (mem_val),
		.result    (res),
		.reg_we    (reg_we),
		.reg_wa    (reg_wa),
		.reg_wd    (reg_wd),
		.mem_we    (mem_we),
		.mem_wa    (mem_wa),
		.mem_wd    (mem_wd),
		.halt_set  (halt_set)
	);

	always_ff @(posedge clk) begin
		if (acc) begin
			instr_s1 <= in_instr;
		end
		if (fire) begin
			res_q <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q  <= 1'b0;
			out_valid_q <= 1'b0;
			halt_q      <= 1'b0;
		end else begin
			if (acc) begin
				s1_valid_q <= 1'b1;
			end else if (fire) begin
				s1_valid_q <= 1'b0;
			end
			if (adv) begin
				out_valid_q <= s1_valid_q;
			end
			if (fire && halt_set) begin
				halt_q <= 1'b1;
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {4'b0, res_q.error, res_q.halted, res_q.branch_target,
		res_q.branch_taken, res_q.print_value, res_q.print_valid};

	`TRMCE_ASSERT_NXT(a_halt_sticky, halt_q, halt_q, "halt flag cleared")
	`TRMCE_ASSERT_IMP(a_halt_no_write, halt_q, !(reg_we_g || mem_we_g), "store written after halt")
	`TRMCE_ASSERT_IMP(a_err_quiet, s1_valid_q && res.error,
		!res.print_valid && !res.branch_taken, "error beat reports print or branch")
	`TRMCE_ASSERT_NXT(a_fire_out, fire, out_valid_q, "executed beat not offered")

endmodule

// ===== hdl/trmce_regfile.sv =====
// register file with two registered read ports, write forwarding and valid bits
module trmce_regfile #(
	parameter int NUM_REGS = trmce_pkg::NUM_REGS_DEF,
	localparam int RIDX_W = $clog2(NUM_REGS)
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        rd_en,
	input  logic [RIDX_W-1:0]           rd_addr0,
	input  logic [RIDX_W-1:0]           rd_addr1,
	input  logic                        wr_en,
	input  logic [RIDX_W-1:0]           wr_addr,
	input  logic [trmce_pkg::DATA_W-1:0] wr_data,
	output logic [trmce_pkg::DATA_W-1:0] rd_data0,
	output logic [trmce_pkg::DATA_W-1:0] rd_data1
);
	import trmce_pkg::*;

	logic [DATA_W-1:0] mem_q [NUM_REGS];
	logic [NUM_REGS-1:0] vld_q;
	logic [DATA_W-1:0] rdata0_s1, rdata1_s1, fwd_s1;
	logic vld0_s1, vld1_s1, hit0_s1, hit1_s1;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rdata0_s1 <= mem_q[rd_addr0];
			rdata1_s1 <= mem_q[rd_addr1];
			fwd_s1    <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q   <= '0;
			vld0_s1 <= 1'b0;
			vld1_s1 <= 1'b0;
			hit0_s1 <= 1'b0;
			hit1_s1 <= 1'b0;
		end else begin
			if (wr_en) begin
				vld_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				vld0_s1 <= vld_q[rd_addr0];
				vld1_s1 <= vld_q[rd_addr1];
				hit0_s1 <= wr_en && (wr_addr == rd_addr0);
				hit1_s1 <= wr_en && (wr_addr == rd_addr1);
			end
		end
	end

	// a never-written register reads as zero
	assign rd_data0 = hit0_s1 ? fwd_s1 : (vld0_s1 ? rdata0_s1 : '0);
	assign rd_data1 = hit1_s1 ? fwd_s1 : (vld1_s1 ? rdata1_s1 : '0);

endmodule

// ===== hdl/trmce_datamem.sv =====
// data memory with one registered read port, write forwarding and valid bits
module trmce_datamem #(
	parameter int MEM_WORDS = trmce_pkg::MEM_WORDS_DEF,
	localparam int AIDX_W = $clog2(MEM_WORDS)
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        rd_en,
	input  logic [AIDX_W-1:0]           rd_addr,
	input  logic                        wr_en,
	input  logic [AIDX_W-1:0]           wr_addr,
	input  logic [trmce_pkg::DATA_W-1:0] wr_data,
	output logic [trmce_pkg::DATA_W-1:0] rd_data
);
	import trmce_pkg::*;

	logic [DATA_W-1:0] mem_q [MEM_WORDS];
	logic [MEM_WORDS-1:0] vld_q;
	logic [DATA_W-1:0] rdata_s1, fwd_s1;
	logic vld_s1, hit_s1;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rdata_s1 <= mem_q[rd_addr];
			fwd_s1   <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q  <= '0;
			vld_s1 <= 1'b0;
			hit_s1 <= 1'b0;
		end else begin
			if (wr_en) begin
				vld_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				vld_s1 <= vld_q[rd_addr];
				hit_s1 <= wr_en && (wr_addr == rd_addr);
			end
		end
	end

	// a never-written word reads as zero
	assign rd_data = hit_s1 ? fwd_s1 : (vld_s1 ? rdata_s1 : '0);

endmodule

// ===== hdl/trmce_exec.sv =====
// instruction execute: operand checks, alu, branch decision and store writes
module trmce_exec #(
	parameter int NUM_REGS  = trmce_pkg::NUM_REGS_DEF,
	parameter int MEM_WORDS = trmce_pkg::MEM_WORDS_DEF,
	localparam int RIDX_W = $clog2(NUM_REGS),
	localparam int AIDX_W = $clog2(MEM_WORDS)
) (
	input  trmce_pkg::instr_t            instr,
	input  logic                         halted_in,
	input  logic [trmce_pkg::DATA_W-1:0] ra_val,
	input  logic [trmce_pkg::DATA_W-1:0] rb_val,
	input  logic [trmce_pkg::DATA_W-1:0] mem_val,
	output trmce_pkg::result_t           result,
	output logic                         reg_we,
	output logic [RIDX_W-1:0]            reg_wa,
	output logic [trmce_pkg::DATA_W-1:0] reg_wd,
	output logic                         mem_we,
	output logic [AIDX_W-1:0]            mem_wa,
	output logic [trmce_pkg::DATA_W-1:0] mem_wd,
	output logic                         halt_set
);
	import trmce_pkg::*;

	logic ok_a, ok_b, ok_adr;
	logic err, pv, bt, blk, reg_wr, mem_wr, hlt;
	logic [DATA_W-1:0] imm32, src, val;
	logic [RIDX_W-1:0] ra_idx, rb_idx;

	assign ok_a   = 32'(instr.reg_a) < NUM_REGS;
	assign ok_b   = 32'(instr.reg_b) < NUM_REGS;
	assign ok_adr = 32'(instr.address) < MEM_WORDS;
	assign imm32  = {1'b0, instr.immediate};
	assign ra_idx = RIDX_W'(instr.reg_a);
	assign rb_idx = RIDX_W'(instr.reg_b);
	assign mem_wa = AIDX_W'(instr.address);

	always_comb begin
		err    = 1'b0;
		pv     = 1'b0;
		bt     = 1'b0;
		val    = '0;
		src    = '0;
		reg_wr = 1'b0;
		reg_wa = ra_idx;
		reg_wd = '0;
		mem_wr = 1'b0;
		mem_wd = '0;
		hlt    = 1'b0;
		unique case (instr.kind)
			KIND_MOV: begin
				unique case (instr.mode)
					MOV_IMM_REG: begin
						err    = !ok_a;
						reg_wr = 1'b1;
						reg_wd = imm32;
					end
					MOV_REG_REG: begin
						err    = !(ok_a && ok_b);
						reg_wr = 1'b1;
						reg_wa = rb_idx;
						reg_wd = ra_val;
					end
					MOV_REG_MEM: begin
						err    = !(ok_a && ok_adr);
						mem_wr = 1'b1;
						mem_wd = ra_val;
					end
					MOV_IMM_MEM: begin
						err    = !ok_adr;
						mem_wr = 1'b1;
						mem_wd = imm32;
					end
					MOV_MEM_REG: begin
						err    = !(ok_b && ok_adr);
						reg_wr = 1'b1;
						reg_wa = rb_idx;
						reg_wd = mem_val;
					end
					default: err = 1'b1;
				endcase
			end
			KIND_ADD, KIND_SUB: begin
				unique case (instr.mode)
					SRC_IMM: begin
						err = !ok_a;
						src = imm32;
					end
					SRC_REG: begin
						err = !(ok_a && ok_b);
						src = rb_val;
					end
					SRC_MEM: begin
						err = !(ok_a && ok_adr);
						src = mem_val;
					end
					default: err = 1'b1;
				endcase
				reg_wr = 1'b1;
				reg_wd = (instr.kind == KIND_ADD) ? (ra_val + src) : (ra_val - src);
			end
			KIND_PRN: begin
				pv = 1'b1;
				unique case (instr.mode)
					SRC_IMM: val = imm32;
					SRC_REG: begin
						err = !ok_a;
						val = ra_val;
					end
					SRC_MEM: begin
						err = !ok_adr;
						val = mem_val;
					end
					default: err = 1'b1;
				endcase
			end
			KIND_JMP: begin
				unique case (instr.mode)
					JMP_ALWAYS: bt = 1'b1;
					JMP_ZERO: begin
						err = !ok_a;
						bt  = (ra_val == '0);
					end
					default: err = 1'b1;
				endcase
			end
			KIND_JPN: begin
				err = !ok_a;
				bt  = ra_val[DATA_W-1] || (ra_val == '0);
			end
			KIND_HLT: hlt = 1'b1;
			default: err = 1'b1;
		endcase
	end

	// once halted nothing changes and only the halt flag reports
	assign blk      = err || halted_in;
	assign reg_we   = reg_wr && !blk;
	assign mem_we   = mem_wr && !blk;
	assign halt_set = hlt && !halted_in;

	always_comb begin
		result.print_valid   = pv && !blk;
		result.print_value   = (pv && !blk) ? val : '0;
		result.branch_taken  = bt && !blk;
		result.branch_target = (bt && !blk) ? instr.target : '0;
		result.halted        = halted_in || hlt;
		result.error         = err && !halted_in;
	end

endmodule

// ===== dv/tiny_register_memory_cpu_executor_tb.sv =====
// self-checking testbench for the register/memory instruction executor
module tiny_register_memory_cpu_executor_tb;
	import trmce_pkg::*;

	localparam int NUM_REGS  = NUM_REGS_DEF;
	localparam int MEM_WORDS = MEM_WORDS_DEF;
	localparam int RES_W     = $bits(result_t);
	localparam int RAND_ITEMS_PER_PHASE = 95;
	localparam logic [30:0] IMM_MAX = 31'h7fffffff;

	// encodings that the block must reject, and a mode value that modeless kinds ignore
	localparam logic [2:0] KIND_BAD     = 3'd7;
	localparam logic [2:0] MOV_MODE_BAD = 3'd5;
	localparam logic [2:0] SRC_MODE_BAD = 3'd3;
	localparam logic [2:0] JMP_MODE_BAD = 3'd2;
	localparam logic [2:0] MODE_ANY     = 3'd7;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata = '0;
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_tdata;

	instr_t  instr_q[$];
	result_t result_q[$];
	int      send_idle_pct = 0;
	int      recv_stall_pct = 0;
	int      mismatch_count = 0;

	logic [31:0] regs_model [NUM_REGS];
	logic [31:0] mem_model [MEM_WORDS];
	logic        halt_model = 1'b0;

	tiny_register_memory_cpu_executor u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		#2000000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	function automatic instr_t mk(logic [2:0] k, logic [2:0] m, logic [2:0] ra,
			logic [2:0] rb, logic [5:0] adr, logic [30:0] imm, logic [7:0] tgt);
		instr_t ins;
		ins.kind = k;
		ins.mode = m;
		ins.reg_a = ra;
		ins.reg_b = rb;
		ins.address = adr;
		ins.immediate = imm;
		ins.target = tgt;
		return ins;
	endfunction

	function automatic instr_t rand_instr();
		instr_t ins;
		int r;
		r = $urandom_range(99);
		if (r < 18) ins.kind = KIND_MOV;
		else if (r < 34) ins.kind = KIND_ADD;
		else if (r < 48) ins.kind = KIND_SUB;
		else if (r < 64) ins.kind = KIND_PRN;
		else if (r < 78) ins.kind = KIND_JMP;
		else if (r < 96) ins.kind = KIND_JPN;
		else ins.kind = KIND_BAD;
		if ($urandom_range(9) == 0) ins.mode = 3'($urandom_range(7));
		else if (ins.kind == KIND_MOV) ins.mode = 3'($urandom_range(4));
		else if (ins.kind == KIND_JMP) ins.mode = 3'($urandom_range(1));
		else ins.mode = 3'($urandom_range(2));
		ins.reg_a = ($urandom_range(11) == 0) ? 3'($urandom_range(7)) : 3'($urandom_range(4));
		ins.reg_b = ($urandom_range(11) == 0) ? 3'($urandom_range(7)) : 3'($urandom_range(4));
		ins.address = ($urandom_range(3) == 0) ? 6'($urandom_range(63)) :
			6'($urandom_range(7));
		case ($urandom_range(3))
			0: ins.immediate = 31'($urandom_range(15));
			1: ins.immediate = IMM_MAX;
			default: ins.immediate = 31'($urandom());
		endcase
		ins.target = 8'($urandom_range(255));
		return ins;
	endfunction

	// executes one instruction on the shadow machine and returns its result beat
	function automatic result_t exec_instr(instr_t ins);
		result_t res;
		logic [31:0] src;
		logic bad;
		logic taken;
		logic ra_ok;
		logic rb_ok;
		logic adr_ok;
		res = '0;
		src = '0;
		bad = 1'b0;
		taken = 1'b0;
		ra_ok = ins.reg_a < NUM_REGS;
		rb_ok = ins.reg_b < NUM_REGS;
		adr_ok = ins.address < MEM_WORDS;
		if (halt_model) begin
			res.halted = 1'b1;
			return res;
		end
		case (ins.kind)
			KIND_MOV: begin
				case (ins.mode)
					MOV_IMM_REG: if (ra_ok) regs_model[ins.reg_a] = {1'b0, ins.immediate};
						else bad = 1'b1;
					MOV_REG_REG: if (ra_ok && rb_ok) regs_model[ins.reg_b] = regs_model[ins.reg_a];
						else bad = 1'b1;
					MOV_REG_MEM: if (ra_ok && adr_ok) mem_model[ins.address] = regs_model[ins.reg_a];
						else bad = 1'b1;
					MOV_IMM_MEM: if (adr_ok) mem_model[ins.address] = {1'b0, ins.immediate};
						else bad = 1'b1;
					MOV_MEM_REG: if (rb_ok && adr_ok) regs_model[ins.reg_b] = mem_model[ins.address];
						else bad = 1'b1;
					default: bad = 1'b1;
				endcase
			end
			KIND_ADD, KIND_SUB: begin
				if (!ra_ok) bad = 1'b1;
				else begin
					case (ins.mode)
						SRC_IMM: src = {1'b0, ins.immediate};
						SRC_REG: if (rb_ok) src = regs_model[ins.reg_b];
							else bad = 1'b1;
						SRC_MEM: if (adr_ok) src = mem_model[ins.address];
							else bad = 1'b1;
						default: bad = 1'b1;
					endcase
					if (!bad) begin
						if (ins.kind == KIND_ADD) regs_model[ins.reg_a] = regs_model[ins.reg_a] + src;
						else regs_model[ins.reg_a] = regs_model[ins.reg_a] - src;
					end
				end
			end
			KIND_PRN: begin
				case (ins.mode)
					SRC_IMM: src = {1'b0, ins.immediate};
					SRC_REG: if (ra_ok) src = regs_model[ins.reg_a];
						else bad = 1'b1;
					SRC_MEM: if (adr_ok) src = mem_model[ins.address];
						else bad = 1'b1;
					default: bad = 1'b1;
				endcase
				if (!bad) begin
					res.print_valid = 1'b1;
					res.print_value = src;
				end
			end
			KIND_JMP: begin
				case (ins.mode)
					JMP_ALWAYS: taken = 1'b1;
					JMP_ZERO: if (ra_ok) taken = (regs_model[ins.reg_a] == 32'd0);
						else bad = 1'b1;
					default: bad = 1'b1;
				endcase
			end
			KIND_JPN: begin
				if (ra_ok) taken = ($signed(regs_model[ins.reg_a]) <= 0);
				else bad = 1'b1;
			end
			KIND_HLT: halt_model = 1'b1;
			default: bad = 1'b1;
		endcase
		if (taken && !bad) begin
			res.branch_taken = 1'b1;
			res.branch_target = ins.target;
		end
		res.halted = halt_model;
		res.error = bad;
		return res;
	endfunction

	function automatic void check_field(string name, logic [31:0] exp, logic [31:0] act);
		if (act !== exp) begin
			$error("%s: expected %0h, got %0h", name, exp, act);
			mismatch_count++;
		end
	endfunction

	// instruction driver, predicts on every accepted beat
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
		end else begin
			if (s_tvalid && s_tready)
				result_q.push_back(exec_instr(instr_t'(s_tdata[$bits(instr_t)-1:0])));
			if (!s_tvalid || s_tready) begin
				if (instr_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					s_tvalid <= 1'b1;
					s_tdata <= IN_TDATA_W'(instr_q.pop_front());
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// result monitor
	always @(posedge clk or negedge arst_n) begin
		result_t act;
		result_t exp;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= recv_stall_pct);
			if (m_tvalid && m_tready) begin
				act = result_t'(m_tdata[RES_W-1:0]);
				if (result_q.size() == 0) begin
					$error("result beat with no instruction outstanding: %0h", m_tdata);
					mismatch_count++;
				end else begin
					exp = result_q.pop_front();
					check_field("print_valid", 32'(exp.print_valid), 32'(act.print_valid));
					check_field("print_value", exp.print_value, act.print_value);
					check_field("branch_taken", 32'(exp.branch_taken), 32'(act.branch_taken));
					check_field("branch_target", 32'(exp.branch_target),
						32'(act.branch_target));
					check_field("halted", 32'(exp.halted), 32'(act.halted));
					check_field("error", 32'(exp.error), 32'(act.error));
					check_field("pad", '0, 32'(m_tdata[OUT_TDATA_W-1:RES_W]));
				end
			end
		end
	end

	task automatic drain();
		while (instr_q.size() != 0 || s_tvalid || result_q.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	initial begin
		for (int i = 0; i < NUM_REGS; i++) regs_model[i] = '0;
		for (int i = 0; i < MEM_WORDS; i++) mem_model[i] = '0;
		repeat (6) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// extremes, every operation but halt, and a set of rejected encodings
		instr_q.push_back(mk(KIND_MOV, MOV_IMM_REG, 0, 0, 0, IMM_MAX, 0));
		instr_q.push_back(mk(KIND_MOV, MOV_IMM_REG, 4, 7, 63, 0, 255));
		instr_q.push_back(mk(KIND_MOV, MOV_REG_REG, 0, 1, 0, 0, 0));
		instr_q.push_back(mk(KIND_ADD, SRC_IMM, 1, 0, 0, IMM_MAX, 0));
		instr_q.push_back(mk(KIND_PRN, SRC_REG, 1, 0, 0, 0, 0));
		instr_q.push_back(mk(KIND_MOV, MOV_REG_MEM, 1, 0, 63, 0, 0));
		instr_q.push_back(mk(KIND_MOV, MOV_IMM_MEM, 7, 7, 0, IMM_MAX, 0));
		instr_q.push_back(mk(KIND_MOV, MOV_MEM_REG, 0, 2, 63, 0, 0));
		instr_q.push_back(mk(KIND_ADD, SRC_REG, 2, 0, 0, 0, 0));
		instr_q.push_back(mk(KIND_SUB, SRC_MEM, 3, 0, 0, 0, 0));
		instr_q.push_back(mk(KIND_SUB, SRC_IMM, 3, 0, 0, IMM_MAX, 0));
		instr_q.push_back(mk(KIND_PRN, SRC_IMM, 7, 7, 0, IMM_MAX, 0));
		instr_q.push_back(mk(KIND_PRN, SRC_MEM, 0, 0, 63, 0, 0));
		instr_q.push_back(mk(KIND_JMP, JMP_ALWAYS, 7, 7, 0, 0, 255));
		instr_q.push_back(mk(KIND_JMP, JMP_ZERO, 4, 0, 0, 0, 8'h80));
		instr_q.push_back(mk(KIND_JMP, JMP_ZERO, 0, 0, 0, 0, 1));
		instr_q.push_back(mk(KIND_JPN, MODE_ANY, 1, 0, 0, 0, 200));
		instr_q.push_back(mk(KIND_JPN, MOV_IMM_REG, 4, 0, 0, 0, 3));
		instr_q.push_back(mk(KIND_JPN, MOV_IMM_REG, 0, 0, 0, 0, 4));
		instr_q.push_back(mk(KIND_BAD, MOV_IMM_REG, 0, 0, 0, IMM_MAX, 255));
		instr_q.push_back(mk(KIND_MOV, MOV_MODE_BAD, 0, 0, 0, 0, 0));
		instr_q.push_back(mk(KIND_ADD, SRC_MODE_BAD, 0, 0, 0, 0, 0));
		instr_q.push_back(mk(KIND_JMP, JMP_MODE_BAD, 0, 0, 0, 0, 255));
		instr_q.push_back(mk(KIND_ADD, SRC_IMM, 5, 0, 0, 1, 0));
		instr_q.push_back(mk(KIND_MOV, MOV_MEM_REG, 0, 7, 0, 0, 0));
		instr_q.push_back(mk(KIND_PRN, SRC_REG, 6, 0, 0, 0, 0));

		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 83; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 83; end
				default: begin send_idle_pct = 17; recv_stall_pct = 17; end
			endcase
			for (int i = 0; i < RAND_ITEMS_PER_PHASE; i++)
				instr_q.push_back(rand_instr());
			drain();
		end

		// halt freezes the machine, later beats are ignored
		instr_q.push_back(mk(KIND_HLT, MODE_ANY, 7, 7, 63, IMM_MAX, 255));
		for (int i = 0; i < 10; i++)
			instr_q.push_back(rand_instr());
		drain();
		repeat (8) @(negedge clk);

		if (mismatch_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/trmce_pkg.sv
hdl/trmce_regfile.sv
hdl/trmce_datamem.sv
hdl/trmce_exec.sv
hdl/tiny_register_memory_cpu_executor.sv
dv/tiny_register_memory_cpu_executor_tb.sv
